// ----- sv/sst_pkg.sv -----
`default_nettype none

package sst_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RISE_STEP_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_STEP_TICKS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TICKS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEPS_PER_TRIGGER = 3'd5;

    // Register reset values
    localparam logic [11:0] RISE_STEP_TICKS_RST    = 12'd40;
    localparam logic [11:0] FALL_STEP_TICKS_RST    = 12'd20;
    localparam logic [15:0] PAUSE_TICKS_RST        = 16'd500;
    localparam logic [7:0]  MIN_ANGLE_RST          = 8'd10;
    localparam logic [7:0]  MAX_ANGLE_RST          = 8'd80;
    localparam logic [7:0]  SWEEPS_PER_TRIGGER_RST = 8'd4;

    // Saturation limits
    localparam logic [15:0] TICKS_MAX = 16'hFFFF;
    localparam logic [7:0]  COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [11:0] rise_step_ticks;
        logic [11:0] fall_step_ticks;
        logic [15:0] pause_ticks;
        logic [7:0]  min_angle;
        logic [7:0]  max_angle;
        logic [7:0]  sweeps_per_trigger;
    } cfg_t;

    typedef struct packed {
        logic       paused;
        logic       trigger;
        logic [7:0] angle;
        logic       angle_valid;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/sst_cfg.sv -----
`default_nettype none

module sst_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [sst_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [sst_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output sst_pkg::cfg_t                       cfg
);

    sst_pkg::cfg_t cfg_reg;

    // Register file, written one register at a time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rise_step_ticks    <= sst_pkg::RISE_STEP_TICKS_RST;
            cfg_reg.fall_step_ticks    <= sst_pkg::FALL_STEP_TICKS_RST;
            cfg_reg.pause_ticks        <= sst_pkg::PAUSE_TICKS_RST;
            cfg_reg.min_angle          <= sst_pkg::MIN_ANGLE_RST;
            cfg_reg.max_angle          <= sst_pkg::MAX_ANGLE_RST;
            cfg_reg.sweeps_per_trigger <= sst_pkg::SWEEPS_PER_TRIGGER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                sst_pkg::REG_RISE_STEP_TICKS:    cfg_reg.rise_step_ticks <= cfg_wdata[11:0];
                sst_pkg::REG_FALL_STEP_TICKS:    cfg_reg.fall_step_ticks <= cfg_wdata[11:0];
                sst_pkg::REG_PAUSE_TICKS:        cfg_reg.pause_ticks     <= cfg_wdata[15:0];
                sst_pkg::REG_MIN_ANGLE:          cfg_reg.min_angle       <= cfg_wdata[7:0];
                sst_pkg::REG_MAX_ANGLE:          cfg_reg.max_angle       <= cfg_wdata[7:0];
                sst_pkg::REG_SWEEPS_PER_TRIGGER: cfg_reg.sweeps_per_trigger <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- sv/sst_core.sv -----
`default_nettype none

module sst_core (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     step_en,
    input  wire logic     restart,
    input  wire sst_pkg::cfg_t cfg,
    output sst_pkg::result_t result
);

    logic [7:0]  position_reg, position_next;
    logic        moving_up_reg, moving_up_next;
    logic        started_reg;
    logic        holding_reg, holding_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [7:0]  count_reg, count_next;

    logic              init;
    logic [15:0]       interval;
    logic signed [9:0] pos_s;
    logic signed [9:0] step_pos;
    logic signed [9:0] min_s;
    logic signed [9:0] max_s;
    logic              valid;
    logic              trig;

    assign init  = !started_reg || restart;
    assign min_s = $signed({2'b00, cfg.min_angle});
    assign max_s = $signed({2'b00, cfg.max_angle});

    // Next state for one tick
    always_comb begin
        position_next  = position_reg;
        moving_up_next = moving_up_reg;
        holding_next   = holding_reg;
        count_next     = count_reg;
        valid          = 1'b0;
        trig           = 1'b0;

        // start or restart, else saturating elapsed count
        if (init) begin
            position_next  = cfg.min_angle;
            moving_up_next = 1'b1;
            holding_next   = 1'b0;
            count_next     = 8'd0;
            ticks_next     = 16'd0;
        end else if (ticks_reg != sst_pkg::TICKS_MAX) begin
            ticks_next = ticks_reg + 16'd1;
        end else begin
            ticks_next = ticks_reg;
        end

        interval = moving_up_next ? {4'd0, cfg.rise_step_ticks}
                                  : {4'd0, cfg.fall_step_ticks};
        pos_s    = $signed({2'b00, position_next});
        step_pos = moving_up_next ? pos_s + 10'sd1 : pos_s - 10'sd1;

        if (holding_next) begin
            // pause at the bottom, then leave
            if (ticks_next >= cfg.pause_ticks) begin
                holding_next   = 1'b0;
                moving_up_next = (position_next == cfg.min_angle);
                ticks_next     = 16'd0;
            end
        end else if (ticks_next >= interval) begin
            ticks_next = 16'd0;
            valid      = 1'b1;
            if (step_pos <= min_s) begin
                // reached the bottom: hold, and count a sweep if coming down
                if (!moving_up_next && count_next != sst_pkg::COUNT_MAX) begin
                    count_next = count_next + 8'd1;
                end
                position_next = cfg.min_angle;
                holding_next  = 1'b1;
            end else if (step_pos >= max_s) begin
                position_next  = cfg.max_angle;
                moving_up_next = 1'b0;
            end else begin
                position_next = step_pos[7:0];
            end
            if (cfg.sweeps_per_trigger != 8'd0 && count_next >= cfg.sweeps_per_trigger) begin
                trig       = 1'b1;
                count_next = 8'd0;
            end
        end
    end

    // State update on each processed tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg  <= 8'd0;
            moving_up_reg <= 1'b0;
            started_reg   <= 1'b0;
            holding_reg   <= 1'b0;
            ticks_reg     <= 16'd0;
            count_reg     <= 8'd0;
        end else if (step_en) begin
            position_reg  <= position_next;
            moving_up_reg <= moving_up_next;
            started_reg   <= 1'b1;
            holding_reg   <= holding_next;
            ticks_reg     <= ticks_next;
            count_reg     <= count_next;
        end
    end

    assign result.angle_valid = valid;
    assign result.angle       = position_next;
    assign result.trigger     = trig;
    assign result.paused      = holding_next;

    // holding can only be entered after the first tick
    a_hold_started: assert property (@(posedge aclk) disable iff (!aresetn)
        holding_reg |-> started_reg)
        else $error("holding set before start");

    // a trigger clears the sweep count on the same tick
    a_trig_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && trig) |=> (count_reg == 8'd0))
        else $error("sweep count not cleared after trigger");

endmodule

`default_nettype wire

// ----- sv/servo_sweep_with_cycle_trigger_unit.sv -----
`default_nettype none

// Servo sweep profile generator. Each item on the s_ channel is one
// millisecond tick (restart in bit 0); each tick yields one result item on
// the m_ channel with the servo angle, a moved flag, the paused flag and a
// one-tick measurement trigger that fires every sweeps_per_trigger sweeps.
// The block takes one tick per clock cycle while m_tready stays high: a
// tick sits in an input register, combinational compare-and-update logic
// against the sweep state produces the result, and an output register
// holds it until taken. The six setup registers are written through
// cfg_wr_en, cfg_addr and cfg_wdata; the user must write them only while no
// tick is in flight, which the block itself does not enforce. Indexes 6 and
// 7 are ignored.
module servo_sweep_with_cycle_trigger_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // tick stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [0] restart
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [15:0]                         m_tdata,   // [0] angle_valid, [8:1] angle,
                                                           // [9] trigger, [10] paused
    // setup registers
    input  wire logic                           cfg_wr_en,
    input  wire logic [sst_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [sst_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    sst_pkg::cfg_t    cfg;
    sst_pkg::result_t result;
    sst_pkg::result_t m_data_reg;

    logic in_valid_reg;
    logic in_restart_reg;
    logic m_valid_reg;
    logic advance;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    sst_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sst_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .restart (in_restart_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_restart_reg <= s_tdata[0];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_data_reg.paused, m_data_reg.trigger,
                       m_data_reg.angle, m_data_reg.angle_valid};

    // a processed tick always lands in the result register
    a_advance_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("processed tick lost");

    // a waiting tick keeps its restart flag
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_restart_reg)))
        else $error("waiting tick dropped or changed");

    // a trigger only fires on a tick that moved the servo
    a_trig_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.trigger) |-> m_data_reg.angle_valid)
        else $error("trigger without a step");

endmodule

`default_nettype wire
